// ===== hw/rtl/tilemap_autotile_classifier_assert.svh =====
// Assertion macros for the tilemap autotile classifier.
// Used by the RTL modules; expects signals named clk and arst_n in scope.
`ifndef TILEMAP_AUTOTILE_CLASSIFIER_ASSERT_SVH
`define TILEMAP_AUTOTILE_CLASSIFIER_ASSERT_SVH

`ifndef ASSERT_OFF

// Property must hold at every clock edge outside reset.
`define TAC_ASSERT(name, prop, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Expression must never be true at a clock edge outside reset.
`define TAC_ASSERT_NEVER(name, expr, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) !(expr)) else $error(msg);

`else

`define TAC_ASSERT(name, prop, msg)
`define TAC_ASSERT_NEVER(name, expr, msg)

`endif

`endif

// ===== hw/rtl/tac_pkg.sv =====
// Shared types, codes and tables for the tilemap autotile classifier.
// No dependencies; imported by tilemap_autotile_classifier.
`default_nettype none

package tac_pkg;

	// Configuration register indexes.
	typedef logic [1:0] reg_idx_t;
	localparam reg_idx_t REG_MAP_WIDTH  = 2'd0;
	localparam reg_idx_t REG_MAP_HEIGHT = 2'd1;
	localparam reg_idx_t REG_SKY_LEVELS = 2'd2;

	// Register values after reset.
	localparam logic [5:0] RST_MAP_WIDTH  = 6'd32;
	localparam logic [7:0] RST_MAP_HEIGHT = 8'd16;
	localparam logic [4:0] RST_SKY_LEVELS = 5'd1;

	// Number of gradient levels the band table covers.
	localparam int MAX_SKY_LEVELS = 16;

	// Input cell kinds that count as solid.
	localparam logic [2:0] UNIT_GROUND   = 3'd3;
	localparam logic [2:0] UNIT_PLATFORM = 3'd4;

	// Output materials.
	localparam logic [1:0] MAT_SKY      = 2'd0;
	localparam logic [1:0] MAT_GROUND   = 2'd1;
	localparam logic [1:0] MAT_PLATFORM = 2'd2;

	// Autotile shapes.
	localparam logic [3:0] SHAPE_TOP_LEFT     = 4'd0;
	localparam logic [3:0] SHAPE_LEFT         = 4'd3;
	localparam logic [3:0] SHAPE_CENTER       = 4'd4;
	localparam logic [3:0] SHAPE_BOTTOM_LEFT  = 4'd6;
	localparam logic [3:0] SHAPE_CONCAVE_TL   = 4'd9;
	localparam logic [3:0] SHAPE_CONCAVE_TR   = 4'd10;
	localparam logic [3:0] SHAPE_CONCAVE_BL   = 4'd11;
	localparam logic [3:0] SHAPE_CONCAVE_BR   = 4'd12;

	// One line buffer word: the two previous rows at one column.
	typedef struct packed {
		logic [1:0] above;
		logic [1:0] middle;
	} word_t;

	// One window column: solid above, material in the middle, solid below.
	typedef struct packed {
		logic       up;
		logic [1:0] mid;
		logic       dn;
	} col_t;

	// Map a cell kind to its material; unknown kinds are sky.
	function automatic logic [1:0] unit_material(input logic [2:0] unit);
		logic [1:0] m;
		if (unit == UNIT_GROUND) begin
			m = MAT_GROUND;
		end else if (unit == UNIT_PLATFORM) begin
			m = MAT_PLATFORM;
		end else begin
			m = MAT_SKY;
		end
		return m;
	endfunction

	function automatic logic mat_solid(input logic [1:0] m);
		return m != MAT_SKY;
	endfunction

	// Rows in one gradient band: twice the Fibonacci number F(level + 1), with F(1) = F(2) = 1.
	function automatic logic [10:0] band_len(input logic [3:0] lvl);
		logic [10:0] n;
		unique case (lvl)
			4'd0:  n = 11'd2;
			4'd1:  n = 11'd2;
			4'd2:  n = 11'd4;
			4'd3:  n = 11'd6;
			4'd4:  n = 11'd10;
			4'd5:  n = 11'd16;
			4'd6:  n = 11'd26;
			4'd7:  n = 11'd42;
			4'd8:  n = 11'd68;
			4'd9:  n = 11'd110;
			4'd10: n = 11'd178;
			4'd11: n = 11'd288;
			4'd12: n = 11'd466;
			4'd13: n = 11'd754;
			4'd14: n = 11'd1220;
			4'd15: n = 11'd1974;
		endcase
		return n;
	endfunction

	// Shape of a solid cell from the solid bits of its 3x3 neighborhood.
	// Bit 0 is the left column, bit 1 the center, bit 2 the right.
	function automatic logic [3:0] shape_of(input logic up_ok, input logic [2:0] up,
			input logic [2:0] mid, input logic [2:0] dn, input logic first,
			input logic last);
		logic [3:0] base;
		logic [3:0] s;
		if (!(up_ok && up[1])) begin
			base = SHAPE_TOP_LEFT;
		end else if (!dn[1]) begin
			base = SHAPE_BOTTOM_LEFT;
		end else begin
			base = SHAPE_LEFT;
		end
		priority if (first) begin
			s = base;
		end else if (last) begin
			s = base + 4'd2;
		end else if (!mid[0]) begin
			s = base;
		end else if (!mid[2]) begin
			s = base + 4'd2;
		end else if (base != SHAPE_LEFT) begin
			s = base + 4'd1;
		end else if (!up[0]) begin
			s = SHAPE_CONCAVE_TL;
		end else if (!up[2]) begin
			s = SHAPE_CONCAVE_TR;
		end else if (!dn[0]) begin
			s = SHAPE_CONCAVE_BL;
		end else if (!dn[2]) begin
			s = SHAPE_CONCAVE_BR;
		end else begin
			s = SHAPE_CENTER;
		end
		return s;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/tilemap_autotile_classifier.sv =====
// Top level of the tilemap autotile classifier: line buffer, 3x3 window and output register.
// Depends on tac_pkg and tilemap_autotile_classifier_assert.svh.
//
// Usage: map cells of a chunk enter in raster order on the cell channel
// (cell_valid/cell_ready, map_unit). Each word on the tile channel
// (tile_valid/tile_ready) is one classified cell, released one row and one
// column after it entered; a tile passes the stage-one and output registers
// once the cell that releases it is accepted. The cfg channel writes
// map_width, map_height and sky_levels; cfg_ready is always high and a new
// chunk picks up the values. Throughput is one cell per cycle while tile_ready
// is high, except that the last cell of each row stays longer in stage one,
// since it releases two tiles through the single output register. After the
// last cell of a chunk, cell_ready stays low through a chunk-width flush row,
// as the final row is read back from the line buffer and sent out; the last
// tile carries last_of_chunk. The line buffer is one single-port-read memory
// of MAX_WIDTH words, read and rewritten once per cell. Reset restores the
// register defaults and starts a new chunk; the buffer needs no clearing pass,
// as every entry is written in a chunk before it is used. When tile_ready is
// low the output word holds and cell_ready drops once the pipeline is full.
`default_nettype none

`include "tilemap_autotile_classifier_assert.svh"

module tilemap_autotile_classifier #(
	parameter int MAX_WIDTH = 32
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  tac_pkg::reg_idx_t cfg_index,
	input  logic [7:0]        cfg_data,
	input  logic              cell_valid,
	output logic              cell_ready,
	input  logic [2:0]        map_unit,
	output logic              tile_valid,
	input  logic              tile_ready,
	output logic [1:0]        material,
	output logic [3:0]        tile_shape,
	output logic [3:0]        sky_level,
	output logic              last_of_chunk
);

	import tac_pkg::*;

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam logic [5:0] MAX_W = 6'(MAX_WIDTH);

	// Configuration registers.
	logic [5:0] map_width_q;
	logic [7:0] map_height_q;
	logic [4:0] sky_levels_q;

	// Chunk position and flush sequencing.
	logic          flush_q;
	logic [CW-1:0] col_q;
	logic [7:0]    row_q;
	logic [5:0]    chunk_w_q;
	logic [7:0]    chunk_h_q;
	logic          ph_up_ok_q;

	// Stage one: cell waiting on its line buffer word.
	logic          valid_s1;
	logic [1:0]    mat_s1;
	logic [CW-1:0] col_s1;
	logic          up_ok_s1;
	logic          e0_s1;
	logic          e1_s1;
	logic          eoc_s1;
	logic          reload_s1;
	logic          adv_s1;
	logic          fwd_hit_s1;
	word_t         fwd_s1;
	word_t         rd_s1;
	logic          e0_done_q;

	// Window columns to the left of the incoming one.
	col_t wl_q;
	col_t wm_q;

	// Sky gradient.
	logic [3:0]  lvl_q;
	logic [10:0] cnt_q;

	// Output register.
	logic       tile_valid_q;
	logic [1:0] material_q;
	logic [3:0] tile_shape_q;
	logic [3:0] sky_level_q;
	logic       last_q;

	// Line buffer.
	word_t line_mem [MAX_WIDTH];

	logic          first_cell;
	logic [5:0]    clamp_w;
	logic [7:0]    clamp_h;
	logic [5:0]    eff_w;
	logic [7:0]    eff_h;
	logic [6:0]    col_p1;
	logic [8:0]    row_p1;
	logic          last_col;
	logic          last_row;
	logic          issue_ok;
	logic          cell_acc;
	logic          ph_issue;
	logic          issue;
	logic          sel_e0;
	logic          pend_any;
	logic          is_final;
	logic          out_load;
	logic          retire;
	word_t         rd_word;
	word_t         wr_word;
	col_t          col_now;
	logic [2:0]    e0_up, e0_mid, e0_dn;
	logic [2:0]    e1_up, e1_mid, e1_dn;
	logic [3:0]    shape_e0;
	logic [3:0]    shape_e1;
	logic [1:0]    res_mat;
	logic [3:0]    res_shape;
	logic [3:0]    top_lvl;

	// Configuration writes; unknown indexes are ignored.
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			map_width_q  <= RST_MAP_WIDTH;
			map_height_q <= RST_MAP_HEIGHT;
			sky_levels_q <= RST_SKY_LEVELS;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_MAP_WIDTH:  map_width_q  <= cfg_data[5:0];
				REG_MAP_HEIGHT: map_height_q <= cfg_data;
				REG_SKY_LEVELS: sky_levels_q <= cfg_data[4:0];
				default: ;
			endcase
		end
	end

	// Chunk geometry: latched at the first cell, clamped to the legal range.
	assign first_cell = !flush_q && (col_q == '0) && (row_q == '0);
	assign clamp_w = (map_width_q == '0) ? 6'd1 :
			((map_width_q > MAX_W) ? MAX_W : map_width_q);
	assign clamp_h = (map_height_q == '0) ? 8'd1 : map_height_q;
	assign eff_w = first_cell ? clamp_w : chunk_w_q;
	assign eff_h = first_cell ? clamp_h : chunk_h_q;
	assign col_p1 = 7'(col_q) + 7'd1;
	assign row_p1 = 9'(row_q) + 9'd1;
	assign last_col = col_p1 >= {1'b0, eff_w};
	assign last_row = row_p1 >= {1'b0, eff_h};

	// Issue: a real cell, or a sky cell of the flush row after the chunk.
	assign issue_ok = !valid_s1 || retire;
	assign cell_ready = issue_ok && !flush_q;
	assign cell_acc = cell_valid && cell_ready;
	assign ph_issue = flush_q && issue_ok;
	assign issue = cell_acc || ph_issue;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			flush_q    <= 1'b0;
			col_q      <= '0;
			row_q      <= '0;
			chunk_w_q  <= 6'd1;
			chunk_h_q  <= 8'd1;
			ph_up_ok_q <= 1'b0;
		end else if (cell_acc) begin
			if (first_cell) begin
				chunk_w_q <= eff_w;
				chunk_h_q <= eff_h;
			end
			if (last_col && last_row) begin
				col_q      <= '0;
				row_q      <= '0;
				flush_q    <= 1'b1;
				ph_up_ok_q <= row_q != '0;
			end else if (last_col) begin
				col_q <= '0;
				row_q <= row_p1[7:0];
			end else begin
				col_q <= col_p1[CW-1:0];
			end
		end else if (ph_issue) begin
			if (last_col) begin
				col_q   <= '0;
				flush_q <= 1'b0;
			end else begin
				col_q <= col_p1[CW-1:0];
			end
		end
	end

	// Line buffer: read at issue, written back when the cell leaves stage one.
	always_ff @(posedge clk) begin
		if (issue) begin
			rd_s1 <= line_mem[col_q];
		end
		if (retire) begin
			line_mem[col_s1] <= wr_word;
		end
	end

	// Stage one payload, including the bypass for a write at the read edge.
	always_ff @(posedge clk) begin
		if (issue) begin
			mat_s1     <= flush_q ? MAT_SKY : unit_material(map_unit);
			col_s1     <= col_q;
			up_ok_s1   <= flush_q ? ph_up_ok_q : (row_q >= 8'd2);
			e0_s1      <= (col_q != '0) && (flush_q || (row_q != '0));
			e1_s1      <= last_col && (flush_q || (row_q != '0));
			eoc_s1     <= flush_q && last_col;
			reload_s1  <= first_cell;
			adv_s1     <= !flush_q && last_col && (row_q != '0);
			fwd_hit_s1 <= retire && (col_s1 == col_q);
			fwd_s1     <= wr_word;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1  <= 1'b0;
			e0_done_q <= 1'b0;
		end else begin
			if (issue) begin
				valid_s1 <= 1'b1;
			end else if (retire) begin
				valid_s1 <= 1'b0;
			end
			if (retire) begin
				e0_done_q <= 1'b0;
			end else if (out_load && sel_e0) begin
				e0_done_q <= 1'b1;
			end
		end
	end

	// New window column from the buffer word and the incoming cell.
	assign rd_word = fwd_hit_s1 ? fwd_s1 : rd_s1;
	assign col_now = '{up: mat_solid(rd_word.above), mid: rd_word.middle,
			dn: mat_solid(mat_s1)};
	assign wr_word = '{above: rd_word.middle, middle: mat_s1};

	// Neighborhood of the cell one column back, and of the row's last cell.
	assign e0_up  = {col_now.up, wm_q.up, wl_q.up};
	assign e0_mid = {mat_solid(col_now.mid), mat_solid(wm_q.mid), mat_solid(wl_q.mid)};
	assign e0_dn  = {col_now.dn, wm_q.dn, wl_q.dn};
	assign e1_up  = {col_now.up, col_now.up, wm_q.up};
	assign e1_mid = {mat_solid(col_now.mid), mat_solid(col_now.mid), mat_solid(wm_q.mid)};
	assign e1_dn  = {col_now.dn, col_now.dn, wm_q.dn};
	assign shape_e0 = shape_of(up_ok_s1, e0_up, e0_mid, e0_dn, col_s1 == CW'(1), 1'b0);
	assign shape_e1 = shape_of(up_ok_s1, e1_up, e1_mid, e1_dn, col_s1 == '0, 1'b1);

	// Result sequencing: the back-column tile first, then the row-end tile.
	assign sel_e0 = e0_s1 && !e0_done_q;
	assign pend_any = valid_s1 && (sel_e0 || e1_s1);
	assign is_final = !(sel_e0 && e1_s1);
	assign out_load = pend_any && (!tile_valid_q || tile_ready);
	assign retire = valid_s1 && (!(sel_e0 || e1_s1) || (out_load && is_final));
	assign res_mat = sel_e0 ? wm_q.mid : col_now.mid;
	assign res_shape = sel_e0 ? shape_e0 : shape_e1;

	// Window shift as the cell leaves stage one.
	always_ff @(posedge clk) begin
		if (retire) begin
			wl_q <= wm_q;
			wm_q <= col_now;
		end
	end

	// Sky gradient: reload at a chunk's first cell, count down at row ends.
	assign top_lvl = (sky_levels_q == '0) ? 4'd0 :
			((sky_levels_q > 5'(MAX_SKY_LEVELS)) ? 4'(MAX_SKY_LEVELS - 1) :
			4'(sky_levels_q - 5'd1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lvl_q <= 4'd0;
			cnt_q <= band_len(4'd0);
		end else if (retire) begin
			if (reload_s1) begin
				lvl_q <= top_lvl;
				cnt_q <= band_len(top_lvl);
			end else if (adv_s1 && (lvl_q != 4'd0)) begin
				if (cnt_q <= 11'd1) begin
					lvl_q <= lvl_q - 4'd1;
					cnt_q <= band_len(lvl_q - 4'd1);
				end else begin
					cnt_q <= cnt_q - 11'd1;
				end
			end
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tile_valid_q <= 1'b0;
		end else if (out_load) begin
			tile_valid_q <= 1'b1;
		end else if (tile_ready) begin
			tile_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			material_q   <= res_mat;
			tile_shape_q <= mat_solid(res_mat) ? res_shape : SHAPE_TOP_LEFT;
			sky_level_q  <= mat_solid(res_mat) ? 4'd0 : lvl_q;
			last_q       <= !sel_e0 && eoc_s1;
		end
	end

	assign tile_valid    = tile_valid_q;
	assign material      = material_q;
	assign tile_shape    = tile_shape_q;
	assign sky_level     = sky_level_q;
	assign last_of_chunk = last_q;

	// A cell with tiles left may only leave stage one while sending its last tile.
	`TAC_ASSERT(a_retire_sends, (retire && pend_any) |-> out_load, "cell retired with tile unsent")
	// The first tile is marked sent only while the row-end tile still waits.
	`TAC_ASSERT(a_e0_pair, e0_done_q |-> (valid_s1 && e0_s1 && e1_s1), "stale first-tile mark")
	// The flush row always starts the next chunk from row zero.
	`TAC_ASSERT(a_flush_row, flush_q |-> (row_q == '0), "row count not cleared during flush")
	// Sky tiles carry no shape.
	`TAC_ASSERT_NEVER(a_sky_shape, tile_valid_q && (material_q == MAT_SKY) && (tile_shape_q != SHAPE_TOP_LEFT), "sky tile with shape")

endmodule

`default_nettype wire
